// ===== hw/rtl/dzz_pkg.sv =====
// ----------------------------------------------------------------------------
// dzz_pkg - shared types, codes and ZigZag helpers
// Register indexes, mode and direction codes, the transaction payload types
// and the ZigZag map functions used by the delta/ZigZag codec.
// ----------------------------------------------------------------------------
package dzz_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIR  = 1'd1;

  // Mode codes; the spare code behaves as passthrough
  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_S16  = 2'd1;
  localparam logic [1:0] MODE_P32  = 2'd2;

  // Direction codes
  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_INV = 1'b1;

  typedef struct packed {
    logic        restart;
    logic        raw_tail;
    logic [31:0] word_a;
    logic [31:0] word_b;
  } item_t;

  typedef struct packed {
    logic [31:0] out_a;
    logic [31:0] out_b;
  } result_t;

  // Map a signed 16-bit difference onto an unsigned code
  function automatic logic [15:0] zig16(input logic [15:0] d);
    return {d[14:0], 1'b0} ^ {16{d[15]}};
  endfunction

  function automatic logic [15:0] unzig16(input logic [15:0] u);
    return {1'b0, u[15:1]} ^ {16{u[0]}};
  endfunction

  function automatic logic [31:0] zig32(input logic [31:0] d);
    return {d[30:0], 1'b0} ^ {32{d[31]}};
  endfunction

  function automatic logic [31:0] unzig32(input logic [31:0] u);
    return {1'b0, u[31:1]} ^ {32{u[0]}};
  endfunction

endpackage

// ===== hw/rtl/dzz_if.sv =====
// ----------------------------------------------------------------------------
// dzz_if - stream channels of the delta/ZigZag codec
// Valid/ready channels for the input items and for the coded results.
// ----------------------------------------------------------------------------
interface dzz_in_if;
  logic        valid;
  logic        ready;
  logic        restart;
  logic        raw_tail;
  logic [31:0] word_a;
  logic [31:0] word_b;

  modport source (output valid, restart, raw_tail, word_a, word_b, input ready);
  modport sink   (input valid, restart, raw_tail, word_a, word_b, output ready);
endinterface

interface dzz_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_a;
  logic [31:0] out_b;

  modport source (output valid, out_a, out_b, input ready);
  modport sink   (input valid, out_a, out_b, output ready);
endinterface

// ===== hw/rtl/dzz_core.sv =====
// ----------------------------------------------------------------------------
// dzz_core - predecessor state and single-pass coding datapath
// Works out the result of one item from the current predecessors and
// updates the predecessors when the transaction is taken.
// ----------------------------------------------------------------------------
module dzz_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  dzz_pkg::item_t   item,
  input  logic [1:0]       mode,
  input  logic             direction,
  output dzz_pkg::result_t result
);

  logic [15:0] last_sample16, last_sample16_next;
  logic [31:0] last_stamp, last_stamp_next;
  logic [31:0] last_value, last_value_next;

  logic [15:0] base16;
  logic [31:0] base_stamp;
  logic [31:0] base_value;
  logic [15:0] x16;
  logic [15:0] sum16;
  logic [31:0] sum_stamp;
  logic [31:0] sum_value;

  // Restart clears the predecessors ahead of the item
  assign base16     = item.restart ? 16'd0 : last_sample16;
  assign base_stamp = item.restart ? 32'd0 : last_stamp;
  assign base_value = item.restart ? 32'd0 : last_value;
  assign x16        = item.word_a[15:0];

  assign sum16     = base16 + dzz_pkg::unzig16(x16);
  assign sum_stamp = base_stamp + dzz_pkg::unzig32(item.word_a);
  assign sum_value = base_value + dzz_pkg::unzig32(item.word_b);

  // Select result and next predecessors
  always_comb begin
    result.out_a       = item.word_a;
    result.out_b       = item.word_b;
    last_sample16_next = base16;
    last_stamp_next    = base_stamp;
    last_value_next    = base_value;
    if (!item.raw_tail && mode == dzz_pkg::MODE_S16) begin
      if (direction == dzz_pkg::DIR_FWD) begin
        result.out_a       = {16'd0, dzz_pkg::zig16(x16 - base16)};
        last_sample16_next = x16;
      end else begin
        result.out_a       = {16'd0, sum16};
        last_sample16_next = sum16;
      end
    end else if (!item.raw_tail && mode == dzz_pkg::MODE_P32) begin
      if (direction == dzz_pkg::DIR_FWD) begin
        result.out_a    = dzz_pkg::zig32(item.word_a - base_stamp);
        result.out_b    = dzz_pkg::zig32(item.word_b - base_value);
        last_stamp_next = item.word_a;
        last_value_next = item.word_b;
      end else begin
        result.out_a    = sum_stamp;
        result.out_b    = sum_value;
        last_stamp_next = sum_stamp;
        last_value_next = sum_value;
      end
    end
  end

  // Advance predecessors on each taken transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample16 <= '0;
      last_stamp    <= '0;
      last_value    <= '0;
    end else if (take) begin
      last_sample16 <= last_sample16_next;
      last_stamp    <= last_stamp_next;
      last_value    <= last_value_next;
    end
  end

`ifndef SYNTHESIS
  // A restart leaves every predecessor at zero when the item is raw tail
  a_restart_raw_clears: assert property (@(posedge clk) disable iff (rst)
    take && item.restart && item.raw_tail |=>
      last_sample16 == 16'd0 && last_stamp == 32'd0 && last_value == 32'd0)
    else $error("restart with raw tail did not clear predecessors");

  // A raw tail without restart never disturbs the predecessors
  a_raw_holds_state: assert property (@(posedge clk) disable iff (rst)
    take && item.raw_tail && !item.restart |=>
      $stable(last_sample16) && $stable(last_stamp) && $stable(last_value))
    else $error("raw tail changed predecessors");

  // The 16-bit channel leaves the paired predecessors alone
  a_s16_keeps_pair: assert property (@(posedge clk) disable iff (rst)
    take && !item.restart && mode == dzz_pkg::MODE_S16 |=>
      $stable(last_stamp) && $stable(last_value))
    else $error("16-bit mode changed paired predecessors");

  // Results in 16-bit mode carry zero upper bits
  a_s16_upper_zero: assert property (@(posedge clk) disable iff (rst)
    take && !item.raw_tail && mode == dzz_pkg::MODE_S16 |->
      result.out_a[31:16] == 16'd0)
    else $error("16-bit result has nonzero upper half");
`endif

endmodule

// ===== hw/rtl/dzz_outbuf.sv =====
// ----------------------------------------------------------------------------
// dzz_outbuf - two-entry output skid buffer
// Holds results for the output channel so that the input ready comes from
// a register and never waits on the receiver combinationally.
// ----------------------------------------------------------------------------
module dzz_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dzz_pkg::result_t push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output dzz_pkg::result_t out_data
);

  logic             head_valid;
  logic             skid_valid;
  dzz_pkg::result_t head;
  dzz_pkg::result_t skid;
  logic             pop;

  assign pop       = head_valid && out_ready;
  assign can_push  = !skid_valid;
  assign out_valid = head_valid;
  assign out_data  = head;

  // Control: head and skid occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (head_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end else if (pop) begin
      head_valid <= 1'b0;
    end
  end

  // Payload: refill the head from the skid, or load the new result
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        head <= skid;
      end
    end else if (push) begin
      if (head_valid && !pop) begin
        skid <= push_data;
      end else begin
        head <= push_data;
      end
    end
  end

`ifndef SYNTHESIS
  // The skid entry is only ever occupied behind a full head
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("skid entry valid with empty head");

  // A stalled head with a waiting skid keeps both entries
  a_stall_keeps_skid: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_ready |=> skid_valid && head_valid)
    else $error("buffer dropped a result under stall");

  // A push into a busy, stalled head lands in the skid entry
  a_push_to_skid: assert property (@(posedge clk) disable iff (rst)
    push && can_push && head_valid && !out_ready |=> skid_valid)
    else $error("push under stall did not fill skid entry");
`endif

endmodule

// ===== hw/rtl/delta_zigzag_codec_top.sv =====
// ----------------------------------------------------------------------------
// delta_zigzag_codec_top - delta/ZigZag stream codec
// Forward or inverse first-order delta coding with ZigZag mapping in
// passthrough, single 16-bit or paired 32-bit mode.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on sample_in (valid/ready); one result per item leaves on
//   code_out (valid/ready) in the same order. Mode and direction are set
//   through the write port (cfg_we, cfg_index, cfg_data) while the stream
//   is idle.
//   Each result is registered in the output buffer when its item is
//   taken. Throughput: one item per cycle while sample_in.ready is high;
//   the predecessor registers are updated in the same cycle, so each item sees the one before it.
//   A two-entry output buffer decouples the sides: sample_in.ready is
//   registered and drops only when both entries hold results the receiver
//   has not taken; it rises again the cycle after a result is taken.
//   Reset (rst, synchronous) empties the buffer, sets mode to passthrough,
//   direction to forward and clears all predecessors to zero.
// ----------------------------------------------------------------------------
module delta_zigzag_codec_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dzz_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dzz_pkg::CFG_DATA_W-1:0]      cfg_data,
  dzz_in_if.sink                              sample_in,
  dzz_out_if.source                           code_out
);

  logic [1:0]       mode;
  logic             direction;
  logic             take;
  logic             can_push;
  dzz_pkg::item_t   item;
  dzz_pkg::result_t result;
  dzz_pkg::result_t out_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= dzz_pkg::MODE_PASS;
      direction <= dzz_pkg::DIR_FWD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dzz_pkg::REG_MODE: mode      <= cfg_data[1:0];
        dzz_pkg::REG_DIR:  direction <= cfg_data[0];
        default:           mode      <= mode;
      endcase
    end
  end

  // Input handshake and payload
  assign sample_in.ready = can_push;
  assign take            = sample_in.valid && can_push;
  assign item.restart    = sample_in.restart;
  assign item.raw_tail   = sample_in.raw_tail;
  assign item.word_a     = sample_in.word_a;
  assign item.word_b     = sample_in.word_b;

  dzz_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (item),
    .mode      (mode),
    .direction (direction),
    .result    (result)
  );

  dzz_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (result),
    .can_push  (can_push),
    .out_valid (code_out.valid),
    .out_ready (code_out.ready),
    .out_data  (out_data)
  );

  assign code_out.out_a = out_data.out_a;
  assign code_out.out_b = out_data.out_b;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - stream testbench for the delta/ZigZag codec
// Steps through every mode and direction, including the spare mode code. The
// first pass gives each setting a few edge-value items; every setting gets a
// run of random items, with random idle gaps on both channels and one long
// hold-off on the result side. A scoreboard predicts every coded result and
// checks it against the result the block delivers.
// ----------------------------------------------------------------------------
module tb_top;

  // The spare mode code has no name in the package
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int unsigned PHASES        = 16;
  localparam int unsigned RAND_PER_PHASE = 80;
  localparam int unsigned HOLD_AT       = 200;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned STALL_LIMIT   = 1000;

  // Predicts the coded words for each accepted item and holds them in order
  class code_scoreboard;
    logic [1:0]       mode;
    logic             dir;
    logic [15:0]      prev_sample;
    logic [31:0]      prev_stamp;
    logic [31:0]      prev_value;
    dzz_pkg::result_t due_codes[$];
    int unsigned      errors;
    int unsigned      items_seen;
    int unsigned      codes_seen;

    function new();
      mode        = dzz_pkg::MODE_PASS;
      dir         = dzz_pkg::DIR_FWD;
      prev_sample = '0;
      prev_stamp  = '0;
      prev_value  = '0;
      errors      = 0;
      items_seen  = 0;
      codes_seen  = 0;
    endfunction

    function void write_reg(input logic [dzz_pkg::CFG_IDX_W-1:0] idx,
                            input logic [dzz_pkg::CFG_DATA_W-1:0] data);
      if (idx == dzz_pkg::REG_MODE) begin
        mode = data;
      end else if (idx == dzz_pkg::REG_DIR) begin
        dir = data[0];
      end
    endfunction

    // Fold the sign into the low bit: negative values invert the doubled word
    function logic [15:0] fold16(input logic [15:0] d);
      return d[15] ? ~(d << 1) : (d << 1);
    endfunction

    function logic [15:0] unfold16(input logic [15:0] u);
      return u[0] ? ~(u >> 1) : (u >> 1);
    endfunction

    function logic [31:0] fold32(input logic [31:0] d);
      return d[31] ? ~(d << 1) : (d << 1);
    endfunction

    function logic [31:0] unfold32(input logic [31:0] u);
      return u[0] ? ~(u >> 1) : (u >> 1);
    endfunction

    function void take_sample(input dzz_pkg::item_t it);
      dzz_pkg::result_t r;
      logic [15:0]      x16;
      logic [15:0]      sum16;
      logic [31:0]      ts;
      logic [31:0]      vv;
      r.out_a = it.word_a;
      r.out_b = it.word_b;
      // Clear predecessors first, even for a raw tail
      if (it.restart) begin
        prev_sample = '0;
        prev_stamp  = '0;
        prev_value  = '0;
      end
      if (!it.raw_tail) begin
        case (mode)
          dzz_pkg::MODE_S16: begin
            x16 = it.word_a[15:0];
            if (dir == dzz_pkg::DIR_FWD) begin
              r.out_a     = {16'h0000, fold16(x16 - prev_sample)};
              prev_sample = x16;
            end else begin
              sum16       = prev_sample + unfold16(x16);
              r.out_a     = {16'h0000, sum16};
              prev_sample = sum16;
            end
          end
          dzz_pkg::MODE_P32: begin
            if (dir == dzz_pkg::DIR_FWD) begin
              r.out_a    = fold32(it.word_a - prev_stamp);
              r.out_b    = fold32(it.word_b - prev_value);
              prev_stamp = it.word_a;
              prev_value = it.word_b;
            end else begin
              ts         = prev_stamp + unfold32(it.word_a);
              vv         = prev_value + unfold32(it.word_b);
              r.out_a    = ts;
              r.out_b    = vv;
              prev_stamp = ts;
              prev_value = vv;
            end
          end
          default: begin
            // passthrough and the spare code leave the words alone
          end
        endcase
      end
      due_codes.push_back(r);
      items_seen++;
    endfunction

    function void check_code(input logic [31:0] got_a, input logic [31:0] got_b);
      dzz_pkg::result_t want;
      codes_seen++;
      if (due_codes.size() == 0) begin
        $error("unexpected result: out_a %h out_b %h", got_a, got_b);
        errors++;
      end else begin
        want = due_codes.pop_front();
        if (want.out_a !== got_a) begin
          $error("out_a mismatch: expected %h, actual %h", want.out_a, got_a);
          errors++;
        end
        if (want.out_b !== got_b) begin
          $error("out_b mismatch: expected %h, actual %h", want.out_b, got_b);
          errors++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return due_codes.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [dzz_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dzz_pkg::CFG_DATA_W-1:0] cfg_data;

  dzz_in_if  sample_bus();
  dzz_out_if code_bus();

  delta_zigzag_codec_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_in (sample_bus),
    .code_out  (code_bus)
  );

  code_scoreboard board = new();

  bit          tx_burst;
  bit          rx_burst;
  bit          rx_held;
  int unsigned stall_cycles;
  logic [31:0] last_a;
  logic [31:0] last_b;

  // Free-running clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check each result transaction as it is taken
  always @(posedge clk) begin
    if (!rst && code_bus.valid && code_bus.ready) begin
      board.check_code(code_bus.out_a, code_bus.out_b);
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (sample_bus.valid && sample_bus.ready) ||
        (code_bus.valid && code_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", stall_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: random hold-offs, no-idle stretches and one long hold
  initial begin : result_sink
    int unsigned gap;
    code_bus.ready = 1'b0;
    rx_burst       = 1'b0;
    rx_held        = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (board.codes_seen % 64 == 0) begin
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      gap = rx_burst ? 0 : $urandom_range(0, 10);
      if (!rx_held && board.codes_seen >= HOLD_AT) begin
        rx_held = 1'b1;
        gap     = HOLD_CYCLES;
      end
      if (gap > 0) begin
        code_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      code_bus.ready <= 1'b1;
      do @(posedge clk); while (!(code_bus.valid && code_bus.ready));
      @(negedge clk);
    end
  end

  // Offer one item after a random gap and hold it until it is taken
  task automatic push_item(input dzz_pkg::item_t it);
    int unsigned gap;
    gap = (tx_burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_bus.valid    <= 1'b1;
    sample_bus.restart  <= it.restart;
    sample_bus.raw_tail <= it.raw_tail;
    sample_bus.word_a   <= it.word_a;
    sample_bus.word_b   <= it.word_b;
    do @(posedge clk); while (!(sample_bus.valid && sample_bus.ready));
    board.take_sample(it);
    last_a = it.word_a;
    last_b = it.word_b;
    @(negedge clk);
  endtask

  // Write both registers back to back, then note them in the scoreboard
  task automatic write_settings(input logic [1:0] m, input logic [1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= dzz_pkg::REG_MODE;
    cfg_data  <= m;
    @(negedge clk);
    cfg_index <= dzz_pkg::REG_DIR;
    cfg_data  <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.write_reg(dzz_pkg::REG_MODE, m);
    board.write_reg(dzz_pkg::REG_DIR, d);
    @(negedge clk);
  endtask

  // Drop the valid and wait until every result has come back
  task automatic drain();
    sample_bus.valid <= 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Mix of small steps, small codes, edge values and full-range words
  function automatic logic [31:0] pick_word(input logic [31:0] prev);
    logic [31:0] w;
    case ($urandom_range(0, 4))
      0: w = $urandom;
      1: w = prev + $urandom_range(0, 64) - 32;
      2: w = $urandom_range(0, 255);
      3: begin
        case ($urandom_range(0, 6))
          0: w = 32'h0000_0000;
          1: w = 32'hFFFF_FFFF;
          2: w = 32'h7FFF_FFFF;
          3: w = 32'h8000_0000;
          4: w = 32'h0000_FFFF;
          5: w = 32'h0000_8000;
          default: w = 32'h0000_7FFF;
        endcase
      end
      default: w = prev + $urandom_range(0, 4096) - 2048;
    endcase
    return w;
  endfunction

  initial begin : stimulus
    logic [1:0]     mode_list [4];
    logic [1:0]     m;
    logic           d;
    dzz_pkg::item_t it;
    int unsigned    p;
    int unsigned    k;
    mode_list = '{dzz_pkg::MODE_PASS, dzz_pkg::MODE_S16, dzz_pkg::MODE_P32, MODE_SPARE};
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = dzz_pkg::REG_MODE;
    cfg_data            = '0;
    sample_bus.valid    = 1'b0;
    sample_bus.restart  = 1'b0;
    sample_bus.raw_tail = 1'b0;
    sample_bus.word_a   = '0;
    sample_bus.word_b   = '0;
    tx_burst            = 1'b0;
    last_a              = '0;
    last_b              = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (p = 0; p < PHASES; p++) begin
      // First pass covers every mode and direction in turn, then random
      if (p < 8) begin
        m = mode_list[p / 2];
        d = (p % 2) ? dzz_pkg::DIR_INV : dzz_pkg::DIR_FWD;
      end else begin
        m = mode_list[$urandom_range(0, 3)];
        d = $urandom_range(0, 1) ? dzz_pkg::DIR_INV : dzz_pkg::DIR_FWD;
      end
      write_settings(m, {1'($urandom_range(0, 1)), d});
      tx_burst = ($urandom_range(0, 3) == 0);

      // Edge values, upper bits in the 16-bit word, restart with raw tail
      if (p < 8) begin
        it = '{restart: 1'b1, raw_tail: 1'b0,
               word_a: 32'hFFFF_FFFF, word_b: 32'h8000_0000};
        push_item(it);
        it = '{restart: 1'b0, raw_tail: 1'b0,
               word_a: 32'h8000_7FFF, word_b: 32'h7FFF_FFFF};
        push_item(it);
        it = '{restart: 1'b1, raw_tail: 1'b1,
               word_a: 32'h0000_8000, word_b: 32'h0000_0000};
        push_item(it);
      end

      // Mostly ordinary stream items, now and then a restart or a tail
      for (k = 0; k < RAND_PER_PHASE; k++) begin
        it.restart  = ($urandom_range(0, 15) == 0);
        it.raw_tail = ($urandom_range(0, 15) == 0);
        it.word_a   = pick_word(last_a);
        it.word_b   = pick_word(last_b);
        push_item(it);
      end
      drain();
    end

    $display("summary: %0d items over %0d settings, %0d results checked",
             board.items_seen, PHASES, board.codes_seen);
    $display("summary: all four mode codes in both directions, %0d mismatches",
             board.errors);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/dzz_pkg.sv
hw/rtl/dzz_if.sv
hw/rtl/dzz_core.sv
hw/rtl/dzz_outbuf.sv
hw/rtl/delta_zigzag_codec_top.sv
tb/sv/tb_top.sv
